[hdl/assert_macros.svh]
// Assertion macros shared by the RTL of the UTF-8 CJK detector.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// Same-cycle implication, disabled during reset.
`define ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// Next-cycle implication, disabled during reset.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`else

`define ASSERT_IMPL(label, clk, rst, ante, cons)
`define ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

[hdl/u8cjk_pkg.sv]
// Package with types, constants and the CJK range function of the UTF-8 CJK detector.
`timescale 1ns / 1ps

package u8cjk_pkg;

   localparam int unsigned CpWidth = 21;

   localparam logic [7:0] LeadMask2 = 8'hE0;
   localparam logic [7:0] LeadCode2 = 8'hC0;
   localparam logic [7:0] LeadMask3 = 8'hF0;
   localparam logic [7:0] LeadCode3 = 8'hE0;
   localparam logic [7:0] LeadMask4 = 8'hF8;
   localparam logic [7:0] LeadCode4 = 8'hF0;
   localparam logic [7:0] ContMask  = 8'hC0;
   localparam logic [7:0] ContCode  = 8'h80;

   localparam logic [CpWidth-1:0] CjkALow  = 21'h003400;
   localparam logic [CpWidth-1:0] CjkAHigh = 21'h004DBF;
   localparam logic [CpWidth-1:0] CjkBLow  = 21'h004E00;
   localparam logic [CpWidth-1:0] CjkBHigh = 21'h009FFF;
   localparam logic [CpWidth-1:0] CjkCLow  = 21'h00F900;
   localparam logic [CpWidth-1:0] CjkCHigh = 21'h00FAFF;
   localparam logic [CpWidth-1:0] CjkDLow  = 21'h020000;
   localparam logic [CpWidth-1:0] CjkDHigh = 21'h0323AF;

   typedef struct packed {
      logic [1:0]         pending;
      logic [CpWidth-1:0] acc;
      logic               halted;
      logic               found;
   } dec_state_type;

   typedef struct packed {
      logic [CpWidth-1:0] code_point;
      logic               point_done;
      logic               point_is_cjk;
      logic               halted;
      logic               cjk_found;
      logic               end_of_text;
   } dec_result_type;

   function automatic logic cjk_range(input logic [CpWidth-1:0] p);
      return ((p >= CjkALow) && (p <= CjkAHigh)) ||
             ((p >= CjkBLow) && (p <= CjkBHigh)) ||
             ((p >= CjkCLow) && (p <= CjkCHigh)) ||
             ((p >= CjkDLow) && (p <= CjkDHigh));
   endfunction

endpackage

[hdl/u8cjk_step.sv]
// Per-byte decode logic: next decoder state and the result for one byte.
`timescale 1ns / 1ps

module u8cjk_step
   import u8cjk_pkg::*;
(
   input  dec_state_type  cur_state,
   input  logic [7:0]     text_byte,
   input  logic           last_byte,
   output dec_state_type  nxt_state,
   output dec_result_type result
);

   dec_state_type      upd;
   logic               done;
   logic [CpWidth-1:0] cp;
   logic               is_cjk;
   logic [CpWidth-1:0] acc_shift;

   assign acc_shift = {cur_state.acc[CpWidth-7:0], text_byte[5:0]};

   always_comb begin
      upd  = cur_state;
      done = 1'b0;
      cp   = '0;
      if (!cur_state.halted) begin
         if (cur_state.pending == 2'd0) begin
            priority if (!text_byte[7]) begin
               cp   = {{(CpWidth-8){1'b0}}, text_byte};
               done = 1'b1;
            end else if ((text_byte & LeadMask2) == LeadCode2) begin
               upd.pending = 2'd1;
               upd.acc     = {{(CpWidth-5){1'b0}}, text_byte[4:0]};
            end else if ((text_byte & LeadMask3) == LeadCode3) begin
               upd.pending = 2'd2;
               upd.acc     = {{(CpWidth-4){1'b0}}, text_byte[3:0]};
            end else if ((text_byte & LeadMask4) == LeadCode4) begin
               upd.pending = 2'd3;
               upd.acc     = {{(CpWidth-3){1'b0}}, text_byte[2:0]};
            end else begin
               upd.halted = 1'b1;
            end
         end else if ((text_byte & ContMask) != ContCode) begin
            upd.halted = 1'b1;
         end else begin
            upd.acc     = acc_shift;
            upd.pending = cur_state.pending - 2'd1;
            if (cur_state.pending == 2'd1) begin
               cp   = acc_shift;
               done = 1'b1;
            end
         end
      end
   end

   assign is_cjk = done && cjk_range(cp);

   always_comb begin
      result.code_point   = cp;
      result.point_done   = done;
      result.point_is_cjk = is_cjk;
      result.halted       = upd.halted || (last_byte && (upd.pending != 2'd0));
      result.cjk_found    = upd.found || is_cjk;
      result.end_of_text  = last_byte;
   end

   always_comb begin
      nxt_state       = upd;
      nxt_state.found = upd.found || is_cjk;
      if (last_byte) begin
         nxt_state = '0;
      end
   end

endmodule

[hdl/utf8_cjk_detector_top.sv]
// Top level of the UTF-8 CJK detector: input register, decoder state and result register.
`timescale 1ns / 1ps

// Streaming UTF-8 decoder that flags code points in the CJK ideograph ranges
// 3400-4DBF, 4E00-9FFF, F900-FAFF and 20000-323AF. One result per byte, in order.
// Throughput is one byte per cycle while rsp_stall is low: the decoder state (pending
// count, 21-bit accumulator, halt and found flags) updates as each byte advances. A req
// transfer loads the input register; the byte then advances into the result register,
// which sets rsp_valid. While a result waits on rsp_stall, one more byte is taken into
// the input register; req_stall then stays high until the result transfers. All
// decoder state clears after the last byte.

`include "assert_macros.svh"

module utf8_cjk_detector_top
   import u8cjk_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [7:0]         req_text_byte,
   input  logic               req_last_byte,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [CpWidth-1:0] rsp_code_point,
   output logic               rsp_point_done,
   output logic               rsp_point_is_cjk,
   output logic               rsp_halted,
   output logic               rsp_cjk_found,
   output logic               rsp_end_of_text
);

   logic           in_valid_ff, in_valid_in;
   logic [7:0]     in_byte_ff;
   logic           in_last_ff;
   logic           out_valid_ff, out_valid_in;
   dec_result_type out_ff;
   dec_state_type  state_ff;
   dec_state_type  state_nxt;
   dec_result_type step_result;
   logic           advance;
   logic           req_take;

   assign advance   = in_valid_ff && (!out_valid_ff || !rsp_stall);
   assign req_stall = in_valid_ff && !advance;
   assign req_take  = req_valid && !req_stall;

   assign in_valid_in  = req_take || (in_valid_ff && !advance);
   assign out_valid_in = advance || (out_valid_ff && rsp_stall);

   u8cjk_step u_step (
      .cur_state (state_ff),
      .text_byte (in_byte_ff),
      .last_byte (in_last_ff),
      .nxt_state (state_nxt),
      .result    (step_result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         state_ff     <= '0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         if (advance) begin
            state_ff <= state_nxt;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_byte_ff <= req_text_byte;
         in_last_ff <= req_last_byte;
      end
      if (advance) begin
         out_ff <= step_result;
      end
   end

   assign rsp_valid        = out_valid_ff;
   assign rsp_code_point   = out_ff.code_point;
   assign rsp_point_done   = out_ff.point_done;
   assign rsp_point_is_cjk = out_ff.point_is_cjk;
   assign rsp_halted       = out_ff.halted;
   assign rsp_cjk_found    = out_ff.cjk_found;
   assign rsp_end_of_text  = out_ff.end_of_text;

   `ASSERT_IMPL(a_no_point_zero, clock, reset, rsp_valid && !rsp_point_done,
      (rsp_code_point == '0) && !rsp_point_is_cjk)
   `ASSERT_IMPL(a_cjk_sets_found, clock, reset, rsp_valid && rsp_point_is_cjk, rsp_cjk_found)
   `ASSERT_NEXT(a_clear_after_last, clock, reset, advance && in_last_ff,
      (state_ff.pending == 2'd0) && !state_ff.halted && !state_ff.found)
   `ASSERT_IMPL(a_stall_only_full, clock, reset, req_stall,
      in_valid_ff && out_valid_ff && rsp_stall)

endmodule
